/* rtl/core/itcrt_pkg.sv */
// Package for the integer to custom radix text unit.
// Holds request/result payload types, character and code constants, FSM states.
// No dependencies.
package itcrt_pkg;

	localparam int VALUE_BITS = 32;
	localparam int LEN_W      = 7;
	localparam int IDX_W      = 6;
	localparam int CHAR_W     = 8;
	localparam int DIG_DEPTH  = VALUE_BITS;
	localparam int DAW        = $clog2(DIG_DEPTH);
	localparam int NDW        = $clog2(DIG_DEPTH + 1);
	localparam int CNT_W      = $clog2(VALUE_BITS);

	localparam logic [CHAR_W-1:0] CH_PLUS  = 8'd43;
	localparam logic [CHAR_W-1:0] CH_MINUS = 8'd45;
	localparam logic [CHAR_W-1:0] CH_NUL   = 8'd0;

	localparam logic ACT_LOAD = 1'b0;
	localparam logic ACT_CONV = 1'b1;

	localparam logic STATUS_OK  = 1'b0;
	localparam logic STATUS_BAD = 1'b1;

	typedef struct packed {
		logic                         action;
		logic [IDX_W-1:0]             digit_index;
		logic [CHAR_W-1:0]            digit_char;
		logic signed [VALUE_BITS-1:0] number;
	} req_t;

	typedef struct packed {
		logic [CHAR_W-1:0] out_char;
		logic              status;
		logic              last;
	} rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHK_RD,
		ST_CHK_TEST,
		ST_CMP_RD,
		ST_CMP_TEST,
		ST_INVALID,
		ST_SIGN,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_EMIT_RD,
		ST_EMIT_MAP,
		ST_EMIT_OUT
	} state_t;

endpackage

/* rtl/core/itcrt_ram.sv */
// Simple dual-port RAM: one write port, one registered read port with enable.
// Used for the digit alphabet and the digit buffer. No dependencies.
module itcrt_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* rtl/core/itcrt_divider.sv */
// Bit-serial restoring divider: one quotient bit per cycle.
// Depends on itcrt_pkg for the value, length and counter widths.
module itcrt_divider (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [itcrt_pkg::VALUE_BITS-1:0]  dividend,
	input  logic [itcrt_pkg::LEN_W-1:0]       divisor,
	output logic                              done,
	output logic [itcrt_pkg::VALUE_BITS-1:0]  quot,
	output logic [itcrt_pkg::LEN_W-1:0]       rem
);

	localparam int VB = itcrt_pkg::VALUE_BITS;
	localparam int LW = itcrt_pkg::LEN_W;
	localparam int CW = itcrt_pkg::CNT_W;

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [VB-1:0] quo_q;
	logic [LW-1:0] rem_q;
	logic [LW-1:0] dvs_q;
	logic [LW:0]   trial;
	logic          ge;

	assign trial = {rem_q, quo_q[VB-1]};
	assign ge    = (trial >= {1'b0, dvs_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == CW'(VB - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? LW'(trial - {1'b0, dvs_q}) : LW'(trial);
			quo_q <= {quo_q[VB-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = quo_q;
	assign rem  = rem_q;

endmodule

/* rtl/core/integer_to_custom_radix_text_unit.sv */
// Top level: signed integer to text in a loaded digit alphabet.
// Depends on itcrt_pkg, itcrt_ram and itcrt_divider.
//
// Usage:
//   req channel (req_valid/req_ready, payload req): a load request
//   (action 0) writes digit_char into alphabet position digit_index and
//   gives no result; positions at or beyond MAX_RADIX are ignored. A convert
//   request (action 1) gives a stream of results on the rsp channel
//   (rsp_valid/rsp_ready, payload rsp), last set on the final one.
//   cfg_we/cfg_wdata set the alphabet length (the radix); write only when idle.
// Sequence:
//   A load is written when accepted. A convert first checks the alphabet
//   (each position read, then compared with every later one, each table
//   read followed by a test state), then the sign, then each digit in turn
//   in the shared serial divider, then each emitted character through the
//   two registered RAM reads.
//   An invalid length or alphabet gives a single result with status set.
//   req_ready is high only between conversions.
// Reset: length clears to 0; alphabet contents stay undefined until loaded.
// A stalled receiver holds the result register and halts the emit sequence.
module integer_to_custom_radix_text_unit #(
	parameter int MAX_RADIX = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_valid,
	output logic                         req_ready,
	input  itcrt_pkg::req_t              req,
	output logic                         rsp_valid,
	input  logic                         rsp_ready,
	output itcrt_pkg::rsp_t              rsp,
	input  logic                         cfg_we,
	input  logic [itcrt_pkg::LEN_W-1:0]  cfg_wdata
);

	localparam int AW  = $clog2(MAX_RADIX);
	localparam int VB  = itcrt_pkg::VALUE_BITS;
	localparam int LW  = itcrt_pkg::LEN_W;
	localparam int CHW = itcrt_pkg::CHAR_W;
	localparam int DAW = itcrt_pkg::DAW;
	localparam int NDW = itcrt_pkg::NDW;

	itcrt_pkg::state_t state_q, state_d;

	logic [LW-1:0]        len_q;
	logic [VB-1:0]        mag_q;
	logic                 neg_q;
	logic [AW-1:0]        ck_idx_q;
	logic [AW-1:0]        cmp_idx_q;
	logic [CHW-1:0]       cur_q;
	logic [NDW-1:0]       nd_q;
	logic [DAW-1:0]       ei_q;

	itcrt_pkg::rsp_t rsp_q, rsp_d;
	logic            rsp_valid_q;
	logic            emit;
	logic            slot_free;
	logic            accept;

	logic            alpha_we;
	logic            alpha_re;
	logic [AW-1:0]   alpha_raddr;
	logic [CHW-1:0]  alpha_rdata;
	logic [AW-1:0]   dig_rdata;
	logic            dig_we;
	logic            dig_re;

	logic            div_start;
	logic            div_done;
	logic [VB-1:0]   div_quot;
	logic [LW-1:0]   div_rem;

	logic            chk_bad;
	logic            cmp_hit;
	logic            len_bad;
	logic            ck_last;
	logic            cmp_last;

	assign req_ready = (state_q == itcrt_pkg::ST_IDLE);
	assign accept    = req_valid && req_ready;
	assign slot_free = !rsp_valid_q || rsp_ready;

	assign alpha_we = accept && (req.action == itcrt_pkg::ACT_LOAD)
		&& (int'(req.digit_index) < MAX_RADIX);
	assign alpha_re = (state_q == itcrt_pkg::ST_CHK_RD) || (state_q == itcrt_pkg::ST_CMP_RD)
		|| (state_q == itcrt_pkg::ST_EMIT_MAP);
	assign alpha_raddr = (state_q == itcrt_pkg::ST_EMIT_MAP) ? dig_rdata
		: (state_q == itcrt_pkg::ST_CMP_RD) ? cmp_idx_q : ck_idx_q;

	assign dig_we = (state_q == itcrt_pkg::ST_DIV_WAIT) && div_done;
	assign dig_re = (state_q == itcrt_pkg::ST_EMIT_RD);

	assign len_bad  = (len_q < LW'(2)) || (int'(len_q) > MAX_RADIX);
	assign chk_bad  = (alpha_rdata == itcrt_pkg::CH_NUL)
		|| (alpha_rdata == itcrt_pkg::CH_PLUS) || (alpha_rdata == itcrt_pkg::CH_MINUS);
	assign cmp_hit  = (alpha_rdata == cur_q);
	assign ck_last  = (int'(ck_idx_q) == int'(len_q) - 1);
	assign cmp_last = (int'(cmp_idx_q) == int'(len_q) - 1);

	itcrt_ram #(.DEPTH(MAX_RADIX), .WIDTH(CHW)) u_alpha (
		.clk   (clk),
		.we    (alpha_we),
		.waddr (AW'(req.digit_index)),
		.wdata (req.digit_char),
		.re    (alpha_re),
		.raddr (alpha_raddr),
		.rdata (alpha_rdata)
	);

	itcrt_ram #(.DEPTH(itcrt_pkg::DIG_DEPTH), .WIDTH(AW)) u_digits (
		.clk   (clk),
		.we    (dig_we),
		.waddr (nd_q[DAW-1:0]),
		.wdata (AW'(div_rem)),
		.re    (dig_re),
		.raddr (ei_q),
		.rdata (dig_rdata)
	);

	itcrt_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (mag_q),
		.divisor  (len_q),
		.done     (div_done),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= itcrt_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		emit      = 1'b0;
		div_start = 1'b0;
		rsp_d     = '{out_char: itcrt_pkg::CH_NUL, status: itcrt_pkg::STATUS_OK, last: 1'b0};
		case (state_q)
			itcrt_pkg::ST_IDLE: begin
				if (accept && (req.action == itcrt_pkg::ACT_CONV)) begin
					state_d = len_bad ? itcrt_pkg::ST_INVALID : itcrt_pkg::ST_CHK_RD;
				end
			end
			itcrt_pkg::ST_CHK_RD: begin
				state_d = itcrt_pkg::ST_CHK_TEST;
			end
			itcrt_pkg::ST_CHK_TEST: begin
				if (chk_bad) begin
					state_d = itcrt_pkg::ST_INVALID;
				end else if (ck_last) begin
					state_d = itcrt_pkg::ST_SIGN;
				end else begin
					state_d = itcrt_pkg::ST_CMP_RD;
				end
			end
			itcrt_pkg::ST_CMP_RD: begin
				state_d = itcrt_pkg::ST_CMP_TEST;
			end
			itcrt_pkg::ST_CMP_TEST: begin
				if (cmp_hit) begin
					state_d = itcrt_pkg::ST_INVALID;
				end else if (cmp_last) begin
					state_d = itcrt_pkg::ST_CHK_RD;
				end else begin
					state_d = itcrt_pkg::ST_CMP_RD;
				end
			end
			itcrt_pkg::ST_INVALID: begin
				rsp_d = '{out_char: itcrt_pkg::CH_NUL, status: itcrt_pkg::STATUS_BAD,
					last: 1'b1};
				if (slot_free) begin
					emit    = 1'b1;
					state_d = itcrt_pkg::ST_IDLE;
				end
			end
			itcrt_pkg::ST_SIGN: begin
				rsp_d = '{out_char: itcrt_pkg::CH_MINUS, status: itcrt_pkg::STATUS_OK,
					last: 1'b0};
				if (!neg_q) begin
					state_d = itcrt_pkg::ST_DIV_GO;
				end else if (slot_free) begin
					emit    = 1'b1;
					state_d = itcrt_pkg::ST_DIV_GO;
				end
			end
			itcrt_pkg::ST_DIV_GO: begin
				div_start = 1'b1;
				state_d   = itcrt_pkg::ST_DIV_WAIT;
			end
			itcrt_pkg::ST_DIV_WAIT: begin
				if (div_done) begin
					state_d = (div_quot == '0) ? itcrt_pkg::ST_EMIT_RD : itcrt_pkg::ST_DIV_GO;
				end
			end
			itcrt_pkg::ST_EMIT_RD: begin
				state_d = itcrt_pkg::ST_EMIT_MAP;
			end
			itcrt_pkg::ST_EMIT_MAP: begin
				state_d = itcrt_pkg::ST_EMIT_OUT;
			end
			itcrt_pkg::ST_EMIT_OUT: begin
				rsp_d = '{out_char: alpha_rdata, status: itcrt_pkg::STATUS_OK, last: (ei_q == '0)};
				if (slot_free) begin
					emit    = 1'b1;
					state_d = (ei_q == '0) ? itcrt_pkg::ST_IDLE : itcrt_pkg::ST_EMIT_RD;
				end
			end
			default: begin
				state_d = itcrt_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q       <= '0;
			rsp_valid_q <= 1'b0;
			ck_idx_q    <= '0;
			cmp_idx_q   <= '0;
			nd_q        <= '0;
			ei_q        <= '0;
			neg_q       <= 1'b0;
		end else begin
			if (cfg_we) begin
				len_q <= cfg_wdata;
			end
			if (emit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (accept && (req.action == itcrt_pkg::ACT_CONV)) begin
				ck_idx_q <= '0;
				nd_q     <= '0;
				neg_q    <= req.number[VB-1];
			end
			if ((state_q == itcrt_pkg::ST_CHK_TEST) && !chk_bad) begin
				cmp_idx_q <= ck_idx_q + AW'(1);
			end
			if ((state_q == itcrt_pkg::ST_CMP_TEST) && !cmp_hit) begin
				if (cmp_last) begin
					ck_idx_q <= ck_idx_q + AW'(1);
				end else begin
					cmp_idx_q <= cmp_idx_q + AW'(1);
				end
			end
			if (dig_we) begin
				nd_q <= nd_q + NDW'(1);
				ei_q <= nd_q[DAW-1:0];
			end
			if ((state_q == itcrt_pkg::ST_EMIT_OUT) && slot_free && (ei_q != '0)) begin
				ei_q <= ei_q - DAW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && (req.action == itcrt_pkg::ACT_CONV)) begin
			mag_q <= req.number[VB-1] ? (VB'(0) - req.number) : req.number;
		end else if (dig_we) begin
			mag_q <= div_quot;
		end
		if (state_q == itcrt_pkg::ST_CHK_TEST) begin
			cur_q <= alpha_rdata;
		end
		if (emit) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

/* test/itcrt_text_checker.sv */
`timescale 1ns / 1ps
// Scoreboard for the integer to custom radix text unit: mirrors the alphabet
// and radix writes, predicts the character stream per convert request, checks results.
// Depends on itcrt_pkg.
module itcrt_text_checker #(
	parameter int MAX_RADIX = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	input  logic                        req_ready,
	input  itcrt_pkg::req_t             req,
	input  logic                        rsp_valid,
	input  logic                        rsp_ready,
	input  itcrt_pkg::rsp_t             rsp,
	input  logic                        cfg_we,
	input  logic [itcrt_pkg::LEN_W-1:0] cfg_wdata,
	output int                          mismatches,
	output int                          pending
);

	localparam int CHW = itcrt_pkg::CHAR_W;
	localparam int LENW = itcrt_pkg::LEN_W;
	localparam int VB  = itcrt_pkg::VALUE_BITS;

	logic [CHW-1:0]    alphabet_copy [MAX_RADIX];
	logic [LENW-1:0]   radix_len;
	itcrt_pkg::rsp_t   text_q [$];

	function automatic bit alphabet_usable();
		int a;
		int b;
		if (radix_len < 2 || radix_len > MAX_RADIX)
			return 1'b0;
		for (a = 0; a < radix_len; a++) begin
			if (alphabet_copy[a] == itcrt_pkg::CH_NUL || alphabet_copy[a] == itcrt_pkg::CH_PLUS ||
			    alphabet_copy[a] == itcrt_pkg::CH_MINUS)
				return 1'b0;
			for (b = a + 1; b < radix_len; b++)
				if (alphabet_copy[b] == alphabet_copy[a])
					return 1'b0;
		end
		return 1'b1;
	endfunction

	function automatic void push_char(input logic [CHW-1:0] ch, input logic st,
		input logic lst);
		itcrt_pkg::rsp_t r;
		r.out_char = ch;
		r.status   = st;
		r.last     = lst;
		text_q.push_back(r);
	endfunction

	function automatic void predict_text(input logic [VB-1:0] value);
		logic [VB-1:0] magnitude;
		logic [VB-1:0] radix;
		logic [VB-1:0] digits [VB+1];
		int n;
		int i;
		if (!alphabet_usable()) begin
			push_char(itcrt_pkg::CH_NUL, itcrt_pkg::STATUS_BAD, 1'b1);
			return;
		end
		radix = VB'(radix_len);
		magnitude = value;
		if (value[VB-1]) begin
			// two's complement negate; most negative value comes out as 2^(N-1)
			magnitude = ~value + 1'b1;
			push_char(itcrt_pkg::CH_MINUS, itcrt_pkg::STATUS_OK, 1'b0);
		end
		n = 0;
		do begin
			digits[n] = magnitude % radix;
			magnitude = magnitude / radix;
			n++;
		end while (magnitude != 0 && n < VB + 1);
		for (i = n - 1; i >= 0; i--)
			push_char(alphabet_copy[digits[i] % MAX_RADIX], itcrt_pkg::STATUS_OK, i == 0);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		itcrt_pkg::rsp_t want;
		int k;
		if (!arst_n) begin
			for (k = 0; k < MAX_RADIX; k++)
				alphabet_copy[k] = '0;
			radix_len = '0;
			text_q.delete();
			mismatches = 0;
			pending = 0;
		end else begin
			if (cfg_we)
				radix_len = cfg_wdata;
			if (req_valid && req_ready) begin
				if (req.action == itcrt_pkg::ACT_LOAD) begin
					if (req.digit_index < MAX_RADIX)
						alphabet_copy[req.digit_index] = req.digit_char;
				end else begin
					predict_text(req.number);
				end
			end
			if (rsp_valid && rsp_ready) begin
				if (text_q.size() == 0) begin
					$error("unexpected result: out_char %0d status %0d last %0d",
						rsp.out_char, rsp.status, rsp.last);
					mismatches++;
				end else begin
					want = text_q.pop_front();
					if (rsp.out_char !== want.out_char) begin
						$error("out_char: expected %0d, got %0d", want.out_char, rsp.out_char);
						mismatches++;
					end
					if (rsp.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, rsp.status);
						mismatches++;
					end
					if (rsp.last !== want.last) begin
						$error("last: expected %0d, got %0d", want.last, rsp.last);
						mismatches++;
					end
				end
			end
			pending = text_q.size();
		end
	end

endmodule

/* test/integer_to_custom_radix_text_unit_tb.sv */
`timescale 1ns / 1ps
// Testbench top for integer_to_custom_radix_text_unit: clock, reset, alphabet
// loads, radix writes and convert requests with random idling.
// Uses itcrt_pkg and itcrt_text_checker.
module integer_to_custom_radix_text_unit_tb;

	localparam int TABLE_DEPTH     = 64;
	localparam int ITEMS_PER_PHASE = 50;
	localparam int SETTLE_CYCLES   = 10;
	localparam int TAIL_CYCLES     = 40;
	localparam int STALL_LIMIT     = 20000;
	localparam int CHW             = itcrt_pkg::CHAR_W;
	localparam int IDXW            = itcrt_pkg::IDX_W;
	localparam int LENW            = itcrt_pkg::LEN_W;
	localparam int VB              = itcrt_pkg::VALUE_BITS;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             req_valid;
	logic             req_ready;
	itcrt_pkg::req_t  req;
	logic             rsp_valid;
	logic             rsp_ready;
	itcrt_pkg::rsp_t  rsp;
	logic             cfg_we;
	logic [LENW-1:0]  cfg_wdata;

	int mismatches;
	int pending;
	int send_idle_pct = 21;
	int recv_idle_pct = 72;
	int holds_wanted = 0;
	int hold_cycles = 0;
	int quiet_cycles = 0;
	int cur_len = 0;
	logic [CHW-1:0] table_mirror [TABLE_DEPTH];

	integer_to_custom_radix_text_unit #(.MAX_RADIX(TABLE_DEPTH)) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	itcrt_text_checker #(.MAX_RADIX(TABLE_DEPTH)) text_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.mismatches(mismatches),
		.pending   (pending)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	// result side: random stalls, plus a long hold-off on request
	initial begin
		int holds_done;
		holds_done = 0;
		rsp_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (holds_wanted != holds_done) begin
				holds_done++;
				rsp_ready <= 1'b0;
				repeat (hold_cycles) @(negedge clk);
			end
			rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	task automatic send_req(input itcrt_pkg::req_t item);
		@(negedge clk);
		if ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		req_valid <= 1'b1;
		req <= item;
		do @(posedge clk); while (!req_ready);
	endtask

	task automatic load_char(input int idx, input logic [CHW-1:0] ch);
		itcrt_pkg::req_t item;
		item.action      = itcrt_pkg::ACT_LOAD;
		item.digit_index = idx[IDXW-1:0];
		item.digit_char  = ch;
		item.number      = $urandom();
		table_mirror[idx] = ch;
		send_req(item);
	endtask

	task automatic convert(input logic [VB-1:0] value);
		itcrt_pkg::req_t item;
		item.action      = itcrt_pkg::ACT_CONV;
		item.digit_index = IDXW'($urandom_range(TABLE_DEPTH - 1));
		item.digit_char  = CHW'($urandom_range(255));
		item.number      = value;
		send_req(item);
	endtask

	task automatic wait_idle();
		@(negedge clk);
		req_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_length(input int len);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_wdata <= len[LENW-1:0];
		@(negedge clk);
		cfg_we <= 1'b0;
		cur_len = len;
	endtask

	function automatic logic [CHW-1:0] fresh_char();
		logic [CHW-1:0] ch;
		bit taken;
		int k;
		do begin
			ch = CHW'($urandom_range(255, 1));
			taken = (ch == itcrt_pkg::CH_PLUS || ch == itcrt_pkg::CH_MINUS);
			for (k = 0; k < TABLE_DEPTH; k++)
				if (table_mirror[k] == ch)
					taken = 1'b1;
		end while (taken);
		return ch;
	endfunction

	// reload any position in use that would make the alphabet invalid
	task automatic repair_alphabet();
		bit bad;
		int i;
		int j;
		if (cur_len < 2 || cur_len > TABLE_DEPTH)
			return;
		for (i = 0; i < cur_len; i++) begin
			bad = (table_mirror[i] == itcrt_pkg::CH_NUL || table_mirror[i] == itcrt_pkg::CH_PLUS ||
			       table_mirror[i] == itcrt_pkg::CH_MINUS);
			for (j = 0; j < i; j++)
				if (table_mirror[j] == table_mirror[i])
					bad = 1'b1;
			if (bad)
				load_char(i, fresh_char());
		end
	endtask

	function automatic int pick_length();
		int sel;
		sel = $urandom_range(99);
		if (sel < 8) begin
			case ($urandom_range(3))
				0: return 0;
				1: return 1;
				2: return $urandom_range(126, TABLE_DEPTH + 1);
				default: return 127;
			endcase
		end
		if (sel < 16)
			return 2;
		if (sel < 24)
			return TABLE_DEPTH;
		return $urandom_range(TABLE_DEPTH, 3);
	endfunction

	function automatic logic [VB-1:0] pick_number();
		case ($urandom_range(9))
			0: begin
				case ($urandom_range(3))
					0: return {1'b1, {(VB-1){1'b0}}};
					1: return {1'b0, {(VB-1){1'b1}}};
					2: return '0;
					default: return '1;
				endcase
			end
			1, 2: return $urandom_range(200) - 100;
			default: return $urandom();
		endcase
	endfunction

	task automatic random_item();
		if ($urandom_range(99) < 35) begin
			if ($urandom_range(99) < 80) begin
				load_char($urandom_range(TABLE_DEPTH - 1), fresh_char());
			end else begin
				case ($urandom_range(3))
					0: load_char($urandom_range(TABLE_DEPTH - 1), itcrt_pkg::CH_NUL);
					1: load_char($urandom_range(TABLE_DEPTH - 1), itcrt_pkg::CH_MINUS);
					2: load_char($urandom_range(TABLE_DEPTH - 1),
						table_mirror[$urandom_range(TABLE_DEPTH - 1)]);
					default: load_char($urandom_range(TABLE_DEPTH - 1),
						CHW'($urandom_range(255)));
				endcase
			end
		end else begin
			if ($urandom_range(99) < 90)
				repair_alphabet();
			convert(pick_number());
		end
	endtask

	initial begin
		int phase;
		int n;
		int i;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// every position written before any conversion reads the table
		for (i = 0; i < TABLE_DEPTH; i++)
			load_char(i, 8'd48 + i[CHW-1:0]);

		set_length(10);
		convert('0);
		convert('1);
		convert({1'b0, {(VB-1){1'b1}}});
		convert({1'b1, {(VB-1){1'b0}}});
		set_length(2);
		convert({1'b1, {(VB-1){1'b0}}});
		convert({1'b0, {(VB-1){1'b1}}});
		set_length(TABLE_DEPTH);
		convert({1'b1, {(VB-1){1'b0}}});
		convert(63);
		convert(-64);
		set_length(0);
		convert(5);
		set_length(1);
		convert(5);
		set_length(TABLE_DEPTH + 1);
		convert(5);
		set_length(127);
		convert(5);
		set_length(16);
		load_char(3, itcrt_pkg::CH_NUL);
		convert(7);
		load_char(3, itcrt_pkg::CH_PLUS);
		convert(7);
		load_char(3, itcrt_pkg::CH_MINUS);
		convert(7);
		load_char(3, 8'd51);
		load_char(5, table_mirror[0]);
		convert(7);
		load_char(5, 8'd53);
		// repeat outside the used range must not matter
		load_char(40, table_mirror[2]);
		convert(-12345);

		for (phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 21 : (phase == 1) ? 72 : 0;
			recv_idle_pct = (phase == 0) ? 72 : (phase == 1) ? 21 : 0;
			for (n = 0; n < ITEMS_PER_PHASE; n++) begin
				if (n % 18 == 0)
					set_length(pick_length());
				if (phase == 2 && n == 30) begin
					set_length(16);
					repair_alphabet();
					hold_cycles = 600;
					holds_wanted++;
					repeat (5) convert(pick_number());
				end
				random_item();
			end
		end

		wait_idle();
		repeat (TAIL_CYCLES) @(negedge clk);
		if (mismatches == 0 && pending == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
